// ===== rtl/dda_line_dot_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// dda line dot generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_DOT_GENERATOR_UNIT_DEFINES_SVH
`define DDA_LINE_DOT_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define DDA_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/dda_ldg_pkg.sv =====
// ----------------------------------------------------------------------------
// dda line dot generator package
// Sequencer step codes, jump conditions, control word and program table.
// ----------------------------------------------------------------------------
package dda_ldg_pkg;

	// sequencer steps, the step counter wraps from the last back to fetch
	typedef enum logic [1:0] {
		STEP_FETCH = 2'd0,
		STEP_SETUP = 2'd1,
		STEP_DIV   = 2'd2,
		STEP_EMIT  = 2'd3
	} step_e_t;

	// jump conditions, a taken jump loads the target, else the counter advances
	typedef enum logic [2:0] {
		COND_NEVER      = 3'd0,
		COND_NO_INPUT   = 3'd1,
		COND_NEW_ANCHOR = 3'd2,
		COND_DIV_MORE   = 3'd3,
		COND_DOTS_LEFT  = 3'd4
	} cond_e_t;

	// register addresses, by word index
	localparam logic REG_DRAW_COLOR = 1'b0;
	localparam logic REG_ERASE_MODE = 1'b1;

	typedef struct packed {
		logic    in_ready;
		logic    setup;
		logic    div_step;
		logic    emit;
		cond_e_t cond;
		step_e_t target;
	} ctrl_t;

	// program table, one control word per step
	function automatic ctrl_t prog_word(input step_e_t step);
		ctrl_t w;
		w = '{in_ready: 1'b0, setup: 1'b0, div_step: 1'b0, emit: 1'b0,
			cond: COND_NEVER, target: STEP_FETCH};
		case (step)
			STEP_FETCH: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NO_INPUT;
				w.target   = STEP_FETCH;
			end
			STEP_SETUP: begin
				w.setup  = 1'b1;
				w.cond   = COND_NEW_ANCHOR;
				w.target = STEP_FETCH;
			end
			STEP_DIV: begin
				w.div_step = 1'b1;
				w.cond     = COND_DIV_MORE;
				w.target   = STEP_DIV;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_DOTS_LEFT;
				w.target = STEP_EMIT;
			end
			default: begin
				w.cond   = COND_NEVER;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/dda_line_dot_generator_unit.sv =====
// ----------------------------------------------------------------------------
// dda line dot generator
// Fans DDA lines out from a held anchor point, one dot per output item.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: point_x, point_y; tuser: new_stroke
//  m_axis    | out       | tdata: dot_x, dot_y, dot_color; tlast: last_dot
//  apb       | in/out    | word 0 draw_color, word 1 erase_mode
//
//  An item that only sets the anchor passes through fetch and setup.
//  A line item passes the fetch, setup, divide and emit steps: the divide
//  loop of the microcoded sequencer retires one quotient bit per cycle,
//  then one dot leaves per cycle while m_axis_tready stays high.
//  The output register lets the next item be fetched while the last dot waits.
//  Reset clears the anchor, the registers and the sequencer to fetch.
//  Output stalls hold the emit step; input stalls hold the fetch step.
// ----------------------------------------------------------------------------
`include "dda_line_dot_generator_unit_defines.svh"

module dda_line_dot_generator_unit
	import dda_ldg_pkg::*;
#(
	parameter int CANVAS_SIZE = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [5:0] point_x, [11:6] point_y
	input  logic [0:0]  s_axis_tuser,   // [0] new_stroke
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [5:0] dot_x, [11:6] dot_y, [19:12] dot_color
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int          ACC_W      = 6 + FRAC_BITS;
	localparam int          DIV_CNT_W  = $clog2(ACC_W + 1);
	localparam logic [5:0]  COORD_MAX  = 6'(CANVAS_SIZE - 1);

	// configuration registers
	logic [7:0] draw_color_q;
	logic       erase_mode_q;

	// sequencer
	step_e_t step_q, step_nxt;
	ctrl_t   ctrl;
	logic    jump;

	// fetched point and anchor
	logic [5:0] point_x_q, point_y_q;
	logic       new_stroke_q;
	logic       anchor_valid_q;
	logic [5:0] anchor_x_q, anchor_y_q;

	// line datapath
	logic                 x_major_q, major_up_q, minor_down_q;
	logic [5:0]           major_q, dot_cnt_q, divisor_q, rem_q;
	logic [ACC_W-1:0]     quo_q, acc_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// output register
	logic       out_valid_q;
	logic [5:0] out_x_q, out_y_q;
	logic [7:0] out_color_q;
	logic       out_last_q;

	// combinational helpers
	logic [5:0]       in_x_clamp, in_y_clamp;
	logic [5:0]       dx, dy, major_dist, minor_dist, minor_start;
	logic             x_major, new_anchor;
	logic [6:0]       rem_sh, rem_sub;
	logic             quo_bit;
	logic [ACC_W-1:0] inc;
	logic [5:0]       minor_now;
	logic             out_load, dot_last;

	// apb access
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= 8'd0;
			erase_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_DRAW_COLOR: draw_color_q <= pwdata[7:0];
				REG_ERASE_MODE: erase_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DRAW_COLOR: prdata = {24'd0, draw_color_q};
			REG_ERASE_MODE: prdata = {31'd0, erase_mode_q};
			default:        prdata = 32'd0;
		endcase
	end

	// step counter and jump logic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= step_nxt;
		end
	end

	always_comb begin
		ctrl = prog_word(step_q);
		case (ctrl.cond)
			COND_NEVER:      jump = 1'b0;
			COND_NO_INPUT:   jump = !s_axis_tvalid;
			COND_NEW_ANCHOR: jump = new_anchor;
			COND_DIV_MORE:   jump = (div_cnt_q != DIV_CNT_W'(1));
			COND_DOTS_LEFT:  jump = !(out_load && dot_last);
			default:         jump = 1'b0;
		endcase
		step_nxt = jump ? ctrl.target : step_e_t'(step_q + 2'd1);
	end

	assign s_axis_tready = ctrl.in_ready;

	// clamp incoming coordinates to the canvas
	assign in_x_clamp = (s_axis_tdata[5:0] > COORD_MAX) ? COORD_MAX : s_axis_tdata[5:0];
	assign in_y_clamp = (s_axis_tdata[11:6] > COORD_MAX) ? COORD_MAX : s_axis_tdata[11:6];

	// line geometry from anchor and point
	assign dx = (anchor_x_q > point_x_q) ? anchor_x_q - point_x_q : point_x_q - anchor_x_q;
	assign dy = (anchor_y_q > point_y_q) ? anchor_y_q - point_y_q : point_y_q - anchor_y_q;
	assign x_major     = (dx >= dy);
	assign major_dist  = x_major ? dx : dy;
	assign minor_dist  = x_major ? dy : dx;
	assign minor_start = x_major ? anchor_y_q : anchor_x_q;
	assign new_anchor  = !anchor_valid_q || new_stroke_q;

	// one restoring division step
	assign rem_sh  = {rem_q, quo_q[ACC_W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign quo_bit = (divisor_q != 6'd0) && (rem_sh >= {1'b0, divisor_q});

	// dot stepping
	assign inc       = minor_down_q ? (~quo_q + ACC_W'(1)) : quo_q;
	assign minor_now = acc_q[FRAC_BITS +: 6];
	assign out_load  = ctrl.emit && (!out_valid_q || m_axis_tready);
	assign dot_last  = (dot_cnt_q == 6'd0);

	// point, anchor and line datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_valid_q <= 1'b0;
			anchor_x_q     <= 6'd0;
			anchor_y_q     <= 6'd0;
		end else if (ctrl.setup && new_anchor) begin
			anchor_valid_q <= 1'b1;
			anchor_x_q     <= point_x_q;
			anchor_y_q     <= point_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.in_ready && s_axis_tvalid) begin
			point_x_q    <= in_x_clamp;
			point_y_q    <= in_y_clamp;
			new_stroke_q <= s_axis_tuser[0];
		end
		if (ctrl.setup && !new_anchor) begin
			x_major_q    <= x_major;
			major_q      <= x_major ? anchor_x_q : anchor_y_q;
			major_up_q   <= x_major ? (anchor_x_q < point_x_q) : (anchor_y_q < point_y_q);
			minor_down_q <= x_major ? (anchor_y_q > point_y_q) : (anchor_x_q > point_x_q);
			dot_cnt_q    <= major_dist;
			divisor_q    <= major_dist;
			rem_q        <= 6'd0;
			quo_q        <= {minor_dist, FRAC_BITS'(0)};
			div_cnt_q    <= DIV_CNT_W'(ACC_W);
			acc_q        <= {minor_start, FRAC_BITS'(0)};
		end
		if (ctrl.div_step) begin
			rem_q     <= quo_bit ? rem_sub[5:0] : rem_sh[5:0];
			quo_q     <= {quo_q[ACC_W-2:0], quo_bit};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
		if (out_load) begin
			major_q   <= major_up_q ? major_q + 6'd1 : major_q - 6'd1;
			acc_q     <= acc_q + inc;
			dot_cnt_q <= dot_cnt_q - 6'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= x_major_q ? major_q : minor_now;
			out_y_q     <= x_major_q ? minor_now : major_q;
			out_color_q <= erase_mode_q ? 8'd0 : draw_color_q;
			out_last_q  <= dot_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_color_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

	// checks on the sequencer and datapath
	`DDA_ASSERT_NEXT(a_last_dot_returns, out_load && dot_last, step_q == STEP_FETCH, "sequencer did not return to fetch after last dot")
	`DDA_ASSERT_SAME(a_minor_on_canvas, step_q == STEP_EMIT, minor_now <= COORD_MAX, "minor coordinate left the canvas")
	`DDA_ASSERT_SAME(a_quotient_bound, step_q == STEP_EMIT, quo_q <= (ACC_W'(1) << FRAC_BITS), "increment exceeds one pixel per step")
	`DDA_ASSERT_SAME(a_div_count_live, step_q == STEP_DIV, div_cnt_q != DIV_CNT_W'(0), "divide loop ran past its bit count")

endmodule
